FILE: rtl/jed_pkg.sv
`timescale 1ns / 1ps

package jed_pkg;

    localparam int unsigned ADC_W  = 12;
    localparam int unsigned TS_W   = 32;
    localparam int unsigned THR_W  = 7;
    localparam int unsigned DBC_W  = 16;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned IDX_W  = 2;

    localparam logic [THR_W-1:0] NAV_THR_RST = 7'd50;
    localparam logic [THR_W-1:0] TGL_THR_RST = 7'd50;
    localparam logic [DBC_W-1:0] DBC_MS_RST  = 16'd50;

    localparam logic [IDX_W-1:0] CFG_NAV_THR = 2'd0;
    localparam logic [IDX_W-1:0] CFG_TGL_THR = 2'd1;
    localparam logic [IDX_W-1:0] CFG_DBC_MS  = 2'd2;

    typedef logic signed [7:0] t_axis;

    typedef enum logic [1:0] {
        MOVE_NONE = 2'd0,
        MOVE_UP   = 2'd1,
        MOVE_DOWN = 2'd2
    } t_move;

    typedef struct packed {
        t_move move;
        logic  toggle;
        logic  press;
        logic  held;
    } t_result;

    // floor(raw * 200 / 4095) - 100; divide by 2^12-1 via shift-and-add
    function automatic t_axis map_axis(input logic [ADC_W-1:0] raw);
        logic [19:0] prod;
        logic [20:0] sum;
        logic [7:0]  quo;
        prod = 20'(raw) * 20'd200;
        sum  = 21'(prod) + 21'(prod >> 12) + 21'd1;
        quo  = 8'(sum >> 12);
        return t_axis'(quo - 8'd100);
    endfunction

    function automatic logic [THR_W-1:0] axis_mag(input t_axis v);
        logic [7:0] a;
        a = v[7] ? 8'(-v) : 8'(v);
        return a[THR_W-1:0];
    endfunction

endpackage

FILE: rtl/jed_debounce.sv
`timescale 1ns / 1ps

module jed_debounce (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_raw_pressed,
    input  logic [jed_pkg::TS_W-1:0]      i_now_ms,
    input  logic [jed_pkg::DBC_W-1:0]     i_debounce_ms,
    output logic                          o_press,
    output logic                          o_held
);

    logic                     r_prev_raw;
    logic [jed_pkg::TS_W-1:0] r_start;
    logic                     r_stable;
    logic [jed_pkg::TS_W-1:0] n_start;
    logic                     n_stable;
    logic [jed_pkg::TS_W-1:0] elapsed;
    logic                     accept;

    always_comb begin
        n_start  = (i_raw_pressed != r_prev_raw) ? i_now_ms : r_start;
        elapsed  = i_now_ms - n_start;
        accept   = (elapsed > jed_pkg::TS_W'(i_debounce_ms)) && (i_raw_pressed != r_stable);
        n_stable = accept ? i_raw_pressed : r_stable;
        o_press  = accept && i_raw_pressed;
        o_held   = n_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw <= 1'b0;
            r_start    <= '0;
            r_stable   <= 1'b0;
        end else if (i_step) begin
            r_prev_raw <= i_raw_pressed;
            r_start    <= n_start;
            r_stable   <= n_stable;
        end
    end

endmodule

FILE: rtl/jed_axis_events.sv
`timescale 1ns / 1ps

module jed_axis_events (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [jed_pkg::ADC_W-1:0]     i_raw_x,
    input  logic [jed_pkg::ADC_W-1:0]     i_raw_y,
    input  logic [jed_pkg::THR_W-1:0]     i_nav_thr,
    input  logic [jed_pkg::THR_W-1:0]     i_tgl_thr,
    output jed_pkg::t_move                o_move,
    output logic                          o_toggle
);

    jed_pkg::t_axis r_prev_x;
    jed_pkg::t_axis r_prev_y;
    logic           r_x_defl;
    logic           r_y_defl;
    jed_pkg::t_axis x_map;
    jed_pkg::t_axis y_map;
    logic           x_defl;
    logic           y_defl;

    always_comb begin
        x_map    = jed_pkg::map_axis(i_raw_x);
        y_map    = jed_pkg::map_axis(i_raw_y);
        x_defl   = jed_pkg::axis_mag(x_map) > i_tgl_thr;
        y_defl   = jed_pkg::axis_mag(y_map) > i_nav_thr;
        o_move   = jed_pkg::MOVE_NONE;
        if (!y_defl && r_y_defl) begin
            if (r_prev_y > 0) begin
                o_move = jed_pkg::MOVE_UP;
            end else if (r_prev_y < 0) begin
                o_move = jed_pkg::MOVE_DOWN;
            end
        end
        o_toggle = !x_defl && r_x_defl && (jed_pkg::axis_mag(r_prev_x) > i_tgl_thr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_x_defl <= 1'b0;
            r_y_defl <= 1'b0;
        end else if (i_step) begin
            r_prev_x <= x_map;
            r_prev_y <= y_map;
            r_x_defl <= x_defl;
            r_y_defl <= y_defl;
        end
    end

endmodule

FILE: rtl/joystick_event_detector_unit.sv
`timescale 1ns / 1ps

// Input register, then result register; mapping, debounce and edge logic sit in one stage.
// Throughput: one item per cycle while the output is not stalled.
// Ready drops only while both stages hold data and the result is not taken.
// Reset (synchronous, active low) clears valids, state and config to defaults.

module joystick_event_detector_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [jed_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [jed_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [jed_pkg::ADC_W-1:0]     i_raw_x,
    input  logic [jed_pkg::ADC_W-1:0]     i_raw_y,
    input  logic                          i_button_pin_level,
    input  logic [jed_pkg::TS_W-1:0]      i_now_ms,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_move,
    output logic                          o_toggle,
    output logic                          o_press,
    output logic                          o_button_held
);

    logic [jed_pkg::THR_W-1:0] r_nav_thr;
    logic [jed_pkg::THR_W-1:0] r_tgl_thr;
    logic [jed_pkg::DBC_W-1:0] r_dbc_ms;

    logic                      r_in_vld;
    logic [jed_pkg::ADC_W-1:0] r_raw_x;
    logic [jed_pkg::ADC_W-1:0] r_raw_y;
    logic                      r_pin;
    logic [jed_pkg::TS_W-1:0]  r_now;

    logic                      r_out_vld;
    jed_pkg::t_result          r_res;
    jed_pkg::t_result          n_res;

    jed_pkg::t_move            n_move;
    logic                      n_toggle;
    logic                      n_press;
    logic                      n_held;

    logic                      step;
    logic                      in_xfer;

    always_comb begin
        step    = r_in_vld && (!r_out_vld || i_ready);
        o_ready = !r_in_vld || step;
        in_xfer = i_valid && o_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nav_thr <= jed_pkg::NAV_THR_RST;
            r_tgl_thr <= jed_pkg::TGL_THR_RST;
            r_dbc_ms  <= jed_pkg::DBC_MS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                jed_pkg::CFG_NAV_THR: r_nav_thr <= i_cfg_data[jed_pkg::THR_W-1:0];
                jed_pkg::CFG_TGL_THR: r_tgl_thr <= i_cfg_data[jed_pkg::THR_W-1:0];
                jed_pkg::CFG_DBC_MS:  r_dbc_ms  <= i_cfg_data[jed_pkg::DBC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_raw_x <= i_raw_x;
            r_raw_y <= i_raw_y;
            r_pin   <= i_button_pin_level;
            r_now   <= i_now_ms;
        end
    end

    jed_debounce u_debounce (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_raw_pressed (!r_pin),
        .i_now_ms      (r_now),
        .i_debounce_ms (r_dbc_ms),
        .o_press       (n_press),
        .o_held        (n_held)
    );

    jed_axis_events u_axis (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_raw_x   (r_raw_x),
        .i_raw_y   (r_raw_y),
        .i_nav_thr (r_nav_thr),
        .i_tgl_thr (r_tgl_thr),
        .o_move    (n_move),
        .o_toggle  (n_toggle)
    );

    always_comb begin
        n_res.move   = n_move;
        n_res.toggle = n_toggle;
        n_res.press  = n_press;
        n_res.held   = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || i_ready) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= n_res;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_move        = r_res.move;
    assign o_toggle      = r_res.toggle;
    assign o_press       = r_res.press;
    assign o_button_held = r_res.held;

    a_press_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_press |-> o_button_held)
        else $error("press reported without held button");

    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_in_vld && r_out_vld && !i_ready)
        else $error("ready low without a full, stalled pipe");

    a_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_in_vld)
        else $error("input transfer lost");

    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_valid)
        else $error("processed item did not reach output");

endmodule

FILE: verif/tb_joystick_event_detector_unit.sv
`timescale 1ns / 1ps

module tb_joystick_event_detector_unit;

    localparam logic [jed_pkg::IDX_W-1:0] CFG_NONE    = 2'd3;
    localparam int                        HOLD_CYCLES = 300;

    typedef struct {
        logic [jed_pkg::ADC_W-1:0] x;
        logic [jed_pkg::ADC_W-1:0] y;
        logic                      pin;
        logic [jed_pkg::TS_W-1:0]  now;
    } t_poll;

    logic                          i_clk;
    logic                          i_rst_n            = 1'b0;
    logic                          i_cfg_we           = 1'b0;
    logic [jed_pkg::IDX_W-1:0]     i_cfg_idx          = '0;
    logic [jed_pkg::CFG_W-1:0]     i_cfg_data         = '0;
    logic                          i_valid            = 1'b0;
    logic                          o_ready;
    logic [jed_pkg::ADC_W-1:0]     i_raw_x            = '0;
    logic [jed_pkg::ADC_W-1:0]     i_raw_y            = '0;
    logic                          i_button_pin_level = 1'b1;
    logic [jed_pkg::TS_W-1:0]      i_now_ms           = '0;
    logic                          o_valid;
    logic                          i_ready            = 1'b0;
    logic [1:0]                    o_move;
    logic                          o_toggle;
    logic                          o_press;
    logic                          o_button_held;

    joystick_event_detector_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_raw_x            (i_raw_x),
        .i_raw_y            (i_raw_y),
        .i_button_pin_level (i_button_pin_level),
        .i_now_ms           (i_now_ms),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_move             (o_move),
        .o_toggle           (o_toggle),
        .o_press            (o_press),
        .o_button_held      (o_button_held)
    );

    t_poll            pending_polls[$];
    jed_pkg::t_result expected_events[$];

    logic [jed_pkg::THR_W-1:0] nav_thr = jed_pkg::NAV_THR_RST;
    logic [jed_pkg::THR_W-1:0] tgl_thr = jed_pkg::TGL_THR_RST;
    logic [jed_pkg::DBC_W-1:0] dbc_ms  = jed_pkg::DBC_MS_RST;

    logic                     last_raw_pressed = 1'b0;
    logic [jed_pkg::TS_W-1:0] bounce_start     = '0;
    logic                     held_state       = 1'b0;
    logic                     y_deflected      = 1'b0;
    logic                     x_deflected      = 1'b0;
    int                       last_x           = 0;
    int                       last_y           = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int hold_cnt       = 0;

    int polls_sent   = 0;
    int results_seen = 0;
    int errors       = 0;
    int n_up         = 0;
    int n_down       = 0;
    int n_toggle     = 0;
    int n_press      = 0;
    int n_phases     = 0;

    logic [jed_pkg::TS_W-1:0] ts      = '0;
    logic                     btn_lvl = 1'b1;
    int                       walk_x  = 2048;
    int                       walk_y  = 2048;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int axis_value(input logic [jed_pkg::ADC_W-1:0] raw);
        return (int'(raw) * 200) / 4095 - 100;
    endfunction

    function automatic int abs_val(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic jed_pkg::t_result predict_poll(input logic [jed_pkg::ADC_W-1:0] rx,
                                                      input logic [jed_pkg::ADC_W-1:0] ry,
                                                      input logic pin,
                                                      input logic [jed_pkg::TS_W-1:0] now);
        jed_pkg::t_result         r;
        int                       x;
        int                       y;
        logic                     pressed;
        logic                     yd;
        logic                     xd;
        logic [jed_pkg::TS_W-1:0] elapsed;
        x       = axis_value(rx);
        y       = axis_value(ry);
        pressed = ~pin;
        r       = '{jed_pkg::MOVE_NONE, 1'b0, 1'b0, 1'b0};
        if (pressed != last_raw_pressed) begin
            bounce_start = now;
        end
        elapsed = now - bounce_start;
        if (elapsed > jed_pkg::TS_W'(dbc_ms) && pressed != held_state) begin
            held_state = pressed;
            r.press    = pressed;
        end
        yd = abs_val(y) > int'(nav_thr);
        xd = abs_val(x) > int'(tgl_thr);
        if (!yd && y_deflected) begin
            if (last_y > 0) begin
                r.move = jed_pkg::MOVE_UP;
            end else if (last_y < 0) begin
                r.move = jed_pkg::MOVE_DOWN;
            end
        end
        if (!xd && x_deflected && abs_val(last_x) > int'(tgl_thr)) begin
            r.toggle = 1'b1;
        end
        r.held           = held_state;
        y_deflected      = yd;
        x_deflected      = xd;
        last_x           = x;
        last_y           = y;
        last_raw_pressed = pressed;
        return r;
    endfunction

    function automatic int next_axis(input int v);
        int n;
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
                0:       n = $urandom_range(0, 400);
                1:       n = $urandom_range(3700, 4095);
                2:       n = $urandom_range(1900, 2200);
                default: n = $urandom_range(0, 4095);
            endcase
        end else begin
            n = v + int'($urandom_range(0, 600)) - 300;
            if (n < 0) n = 0;
            if (n > 4095) n = 4095;
        end
        return n;
    endfunction

    task automatic add_poll(input logic [jed_pkg::ADC_W-1:0] x,
                            input logic [jed_pkg::ADC_W-1:0] y,
                            input logic pin, input logic [jed_pkg::TS_W-1:0] now);
        t_poll p;
        p.x   = x;
        p.y   = y;
        p.pin = pin;
        p.now = now;
        pending_polls.push_back(p);
    endtask

    task automatic queue_polls(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                ts = $urandom;
            end else if (r < 10) begin
                ts = ts + jed_pkg::TS_W'(dbc_ms) + $urandom_range(0, 2);
            end else begin
                ts = ts + $urandom_range(0, 12);
            end
            if ($urandom_range(0, 99) < 8) begin
                btn_lvl = ~btn_lvl;
            end
            walk_x = next_axis(walk_x);
            walk_y = next_axis(walk_y);
            if ($urandom_range(0, 99) < 5) begin
                add_poll(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                         1'($urandom_range(0, 1)), ts);
            end else begin
                add_poll(12'(walk_x), 12'(walk_y),
                         ($urandom_range(0, 99) < 12) ? ~btn_lvl : btn_lvl, ts);
            end
        end
    endtask

    task automatic settle();
        while (pending_polls.size() != 0 || expected_events.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [jed_pkg::IDX_W-1:0] idx,
                           input logic [jed_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            jed_pkg::CFG_NAV_THR: nav_thr <= data[jed_pkg::THR_W-1:0];
            jed_pkg::CFG_TGL_THR: tgl_thr <= data[jed_pkg::THR_W-1:0];
            jed_pkg::CFG_DBC_MS:  dbc_ms  <= data[jed_pkg::DBC_W-1:0];
            default:     ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int n, input int send_pct, input int recv_pct,
                             input bit hold);
        @(posedge i_clk);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
        if (hold) begin
            hold_req <= 1'b1;
        end
        @(negedge i_clk);
        queue_polls(n);
        n_phases++;
        settle();
    endtask

    always @(posedge i_clk) begin : driver
        t_poll            nxt;
        jed_pkg::t_result exp_r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                exp_r = predict_poll(i_raw_x, i_raw_y, i_button_pin_level, i_now_ms);
                expected_events.push_back(exp_r);
                polls_sent++;
                if (exp_r.move == jed_pkg::MOVE_UP) n_up++;
                if (exp_r.move == jed_pkg::MOVE_DOWN) n_down++;
                if (exp_r.toggle) n_toggle++;
                if (exp_r.press) n_press++;
            end
            if (!i_valid || o_ready) begin
                if (pending_polls.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_polls.pop_front();
                    i_valid            <= 1'b1;
                    i_raw_x            <= nxt.x;
                    i_raw_y            <= nxt.y;
                    i_button_pin_level <= nxt.pin;
                    i_now_ms           <= nxt.now;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
            i_ready  <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        jed_pkg::t_result got;
        jed_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_move, o_toggle, o_press, o_button_held};
            results_seen++;
            if (expected_events.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("ERROR %0t: unexpected result move=%0d toggle=%0b press=%0b held=%0b",
                             $realtime, got.move, got.toggle, got.press, got.held);
                end
            end else begin
                want = expected_events.pop_front();
                if (got.move !== want.move || got.toggle !== want.toggle ||
                    got.press !== want.press || got.held !== want.held) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("ERROR %0t: result %0d exp move=%0d toggle=%0b press=%0b held=%0b",
                                 $realtime, results_seen, want.move, want.toggle,
                                 want.press, want.held);
                        $display("        got move=%0d toggle=%0b press=%0b held=%0b",
                                 got.move, got.toggle, got.press, got.held);
                    end
                end
            end
        end
    end

    initial begin : main
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // axis extremes, moves both ways, toggles, debounce, release and timestamp wrap
        add_poll(12'd2048, 12'd2048, 1'b1, 32'd0);
        add_poll(12'd2048, 12'd4095, 1'b1, 32'd5);
        add_poll(12'd2048, 12'd2048, 1'b1, 32'd10);
        add_poll(12'd2048, 12'd0,    1'b1, 32'd15);
        add_poll(12'd2047, 12'd2047, 1'b1, 32'd20);
        add_poll(12'd4095, 12'd2048, 1'b1, 32'd25);
        add_poll(12'd2048, 12'd2048, 1'b1, 32'd30);
        add_poll(12'd0,    12'd0,    1'b1, 32'd35);
        add_poll(12'd2048, 12'd2048, 1'b1, 32'd40);
        add_poll(12'hAAA,  12'h555,  1'b0, 32'd100);
        add_poll(12'h555,  12'hAAA,  1'b0, 32'd130);
        add_poll(12'd2048, 12'd2048, 1'b0, 32'd150);
        add_poll(12'd2048, 12'd2048, 1'b0, 32'd151);
        add_poll(12'd2048, 12'd2048, 1'b1, 32'd160);
        add_poll(12'd2048, 12'd2048, 1'b0, 32'd165);
        add_poll(12'd2048, 12'd2048, 1'b1, 32'd170);
        add_poll(12'd2048, 12'd2048, 1'b1, 32'd221);
        add_poll(12'd2048, 12'd2048, 1'b0, 32'hFFFF_FFE0);
        add_poll(12'd2048, 12'd2048, 1'b0, 32'h0000_0013);
        add_poll(12'd2048, 12'd2048, 1'b1, 32'h0000_0020);
        add_poll(12'd4095, 12'd4095, 1'b1, 32'h0000_0030);
        add_poll(12'd2048, 12'd2048, 1'b1, 32'h0000_0040);
        n_phases++;
        settle();

        // X leaves deflection after the toggle threshold was raised past it
        add_poll(12'd3276, 12'd2048, 1'b1, 32'h0000_0050);
        settle();
        set_reg(jed_pkg::CFG_TGL_THR, 16'd70);
        add_poll(12'd2048, 12'd2048, 1'b1, 32'h0000_0051);
        n_phases++;
        settle();

        ts = 32'h0000_0100;
        set_reg(CFG_NONE, 16'd7);
        set_reg(jed_pkg::CFG_NAV_THR, 16'd0);
        set_reg(jed_pkg::CFG_TGL_THR, 16'd0);
        set_reg(jed_pkg::CFG_DBC_MS, 16'd0);
        run_phase(300, 0, 0, 1'b0);

        set_reg(jed_pkg::CFG_NAV_THR, 16'd100);
        set_reg(jed_pkg::CFG_TGL_THR, 16'd100);
        set_reg(jed_pkg::CFG_DBC_MS, 16'd20);
        run_phase(300, 75, 0, 1'b0);

        ts = 32'hFFFF_F000;
        set_reg(jed_pkg::CFG_NAV_THR, 16'd127);
        set_reg(jed_pkg::CFG_TGL_THR, 16'd127);
        set_reg(jed_pkg::CFG_DBC_MS, 16'hFFFF);
        run_phase(250, 0, 75, 1'b0);

        set_reg(jed_pkg::CFG_NAV_THR, 16'd30);
        set_reg(jed_pkg::CFG_TGL_THR, 16'd80);
        set_reg(jed_pkg::CFG_DBC_MS, 16'd10);
        run_phase(300, 32, 32, 1'b0);

        set_reg(jed_pkg::CFG_NAV_THR, 16'd50);
        set_reg(jed_pkg::CFG_TGL_THR, 16'd50);
        set_reg(jed_pkg::CFG_DBC_MS, 16'd50);
        run_phase(300, 0, 0, 1'b1);

        for (int k = 0; k < 4; k++) begin
            set_reg(jed_pkg::CFG_NAV_THR, 16'($urandom_range(0, 127)));
            set_reg(jed_pkg::CFG_TGL_THR, 16'($urandom_range(0, 127)));
            set_reg(jed_pkg::CFG_DBC_MS, 16'($urandom_range(0, 60)));
            run_phase(125, $urandom_range(0, 75), $urandom_range(0, 75), 1'b0);
        end

        repeat (10) @(posedge i_clk);
        $display("Polls: %0d in %0d phases, results checked: %0d, mismatches: %0d",
                 polls_sent, n_phases, results_seen, errors);
        $display("Events seen: %0d up, %0d down, %0d toggles, %0d presses",
                 n_up, n_down, n_toggle, n_press);
        if (errors == 0 && expected_events.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
